// ----- hw/rtl/ber_sequence_header_parser_macros.svh -----
// Assertion macros used by the checker file bshp_checker.sv.
`ifndef BER_SEQUENCE_HEADER_PARSER_MACROS_SVH
`define BER_SEQUENCE_HEADER_PARSER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define BSHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define BSHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hw/rtl/bshp_pkg.sv -----
// -----------------------------------------------------------------------------
// bshp_pkg
// Types, tag constants and schema tables of the sequence-header parser.
// -----------------------------------------------------------------------------
package bshp_pkg;

  localparam int unsigned StackDepthDef = 8;
  localparam int unsigned IntBytesDef   = 4;

  localparam logic [7:0] TagSeq    = 8'h30;
  localparam logic [7:0] TagIndef  = 8'h80;
  localparam logic [7:0] TagStr    = 8'h1A;
  localparam logic [7:0] TagInt    = 8'h02;
  localparam logic [7:0] TagEoc    = 8'h00;
  localparam logic [7:0] TagIdLo   = 8'hA0;
  localparam logic [7:0] TagIdHi   = 8'hB3;

  typedef enum logic [2:0] {
    EvSbyte = 3'd0,
    EvSend  = 3'd1,
    EvInt   = 3'd2,
    EvId    = 3'd3,
    EvRec   = 3'd4,
    EvList  = 3'd5,
    EvErr   = 3'd6
  } event_kind_e;

  typedef enum logic [2:0] {
    KSeq   = 3'd0,
    KWrap  = 3'd1,
    KStr   = 3'd2,
    KInt   = 3'd3,
    KWlist = 3'd4
  } node_kind_e;

  localparam logic [5:0] NList  = 6'd1;
  localparam logic [5:0] NDef   = 6'd2;
  localparam logic [5:0] NIdseq = 6'd4;

  typedef enum logic [16:0] {
    PIdle    = 17'h00001,
    PIdleLen = 17'h00002,
    PTag     = 17'h00004,
    PTagSe   = 17'h00008,
    PClen    = 17'h00010,
    PW30     = 17'h00020,
    PW80     = 17'h00040,
    PEoc2    = 17'h00080,
    PEoc3    = 17'h00100,
    PEoc4    = 17'h00200,
    PSlen    = 17'h00400,
    PSlenx   = 17'h00800,
    PSdata   = 17'h01000,
    PIlen    = 17'h02000,
    PIlenx   = 17'h04000,
    PIfirst  = 17'h08000,
    PIdata   = 17'h10000
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [5:0]  field_code;
    logic [31:0] event_value;
  } out_item_t;

  function automatic node_kind_e kind_of(input logic [5:0] n);
    node_kind_e k;
    k = KSeq;
    unique case (n)
      6'd3, 6'd12, 6'd15, 6'd16, 6'd18, 6'd19, 6'd20, 6'd25, 6'd27, 6'd28,
      6'd29, 6'd31, 6'd34, 6'd36, 6'd39, 6'd40, 6'd45: k = KStr;
      6'd5, 6'd9, 6'd11, 6'd14, 6'd21, 6'd23, 6'd33, 6'd37, 6'd42, 6'd43,
      6'd44, 6'd46, 6'd47, 6'd48: k = KInt;
      6'd4, 6'd13, 6'd17, 6'd22, 6'd24, 6'd30, 6'd35, 6'd41: k = KWrap;
      6'd6, 6'd7, 6'd8: k = KWlist;
      default: k = KSeq;
    endcase
    return k;
  endfunction

  // Child node for a context tag (or the 30 tag under the list), zero when the schema has no such edge.
  function automatic logic [5:0] child_of(input logic [5:0] t, input logic [7:0] b);
    logic [5:0] c;
    logic [3:0] i;
    c = 6'd0;
    i = b[3:0];
    if (t == NList) begin
      if (b == TagSeq) c = NDef;
    end else if (b[7:4] == 4'hA) begin
      unique case (t)
        6'd2:  if (i <= 4'd5) c = 6'd3 + {2'b0, i};
        6'd10: if (i <= 4'd1) c = 6'd11 + {2'b0, i};
        6'd13: if (i <= 4'd2) c = 6'd14 + {2'b0, i};
        6'd17: if (i <= 4'd3) c = 6'd18 + {2'b0, i};
        6'd22: if (i <= 4'd1) c = 6'd23 + {2'b0, i};
        6'd24: begin
          if (i == 4'd0) c = 6'd25;
          else if (i == 4'd1) c = 6'd26;
          else if (i == 4'd2) c = 6'd29;
        end
        6'd26: if (i <= 4'd1) c = 6'd27 + {2'b0, i};
        6'd30: if (i <= 4'd1) c = 6'd31 + {2'b0, i};
        6'd32: if (i <= 4'd1) c = 6'd33 + {2'b0, i};
        6'd35: if (i <= 4'd3) c = 6'd36 + {2'b0, i};
        6'd38: if (i <= 4'd1) c = 6'd40 + {2'b0, i};
        6'd41: if (i <= 4'd6) c = 6'd42 + {2'b0, i};
        default: c = 6'd0;
      endcase
    end
    return c;
  endfunction

  function automatic logic [5:0] id_choice(input logic [4:0] c);
    logic [5:0] n;
    unique case (c)
      5'd0: n = 6'd10;
      5'd1, 5'd2, 5'd11: n = 6'd9;
      5'd3: n = 6'd13;
      5'd8: n = 6'd22;
      5'd10: n = 6'd30;
      5'd14: n = 6'd35;
      default: n = 6'd17;
    endcase
    return n;
  endfunction

endpackage

// ----- hw/rtl/bshp_stream_if.sv -----
// -----------------------------------------------------------------------------
// bshp_stream_if
// Valid/ready channel carrying one payload of a given type.
// -----------------------------------------------------------------------------
interface bshp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/ber_sequence_header_parser.sv -----
// -----------------------------------------------------------------------------
// ber_sequence_header_parser
// Streaming BER parser for a list of sequence-header records.
// -----------------------------------------------------------------------------
// Usage:
//   in_i carries one byte of the BER stream per request (data_byte).
//   out_o carries events (event_kind, field_code, event_value); each byte
//   causes zero or one event.
//   A byte is decoded in the cycle it is accepted; its event is registered
//   in the output buffer and presented on out_o from there.
//   Throughput is one byte per cycle while in_i.ready is high; the parser
//   state register update is the only loop.
//   A two-entry output buffer keeps input accepted while one event waits;
//   when both entries are full, in_i.ready drops until out_o drains.
//   Reset clears the parser to wait for the outer 30 80 list header and
//   empties the output buffer.
//   An error event also returns the parser to that initial state.
// -----------------------------------------------------------------------------
module ber_sequence_header_parser #(
  parameter int unsigned StackDepth = bshp_pkg::StackDepthDef,
  parameter int unsigned IntBytes   = bshp_pkg::IntBytesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bshp_stream_if.sink   in_i,
  bshp_stream_if.source out_o
);
  import bshp_pkg::*;

  logic      space, step, ev_valid;
  out_item_t ev;

  assign in_i.ready = space;
  assign step       = in_i.valid && space;

  bshp_core #(.StackDepth(StackDepth), .IntBytes(IntBytes)) u_core (
    .clk_i, .rst_ni, .step_i(step), .byte_i(in_i.payload.data_byte),
    .ev_valid_o(ev_valid), .ev_o(ev)
  );

  bshp_out_reg u_out (
    .clk_i, .rst_ni, .in_valid_i(ev_valid), .in_item_i(ev),
    .space_o(space), .out_o(out_o)
  );
endmodule

// ----- hw/rtl/bshp_core.sv -----
// -----------------------------------------------------------------------------
// bshp_core
// Parser state and combinational next-state and event logic for one byte.
// -----------------------------------------------------------------------------
module bshp_core #(
  parameter int unsigned StackDepth = bshp_pkg::StackDepthDef,
  parameter int unsigned IntBytes   = bshp_pkg::IntBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  output logic                  ev_valid_o,
  output bshp_pkg::out_item_t   ev_o
);
  import bshp_pkg::*;

  localparam int unsigned PtrW = $clog2(StackDepth + 1);
  localparam int unsigned IdxW = $clog2(StackDepth);

  phase_e            phase_q, phase_d;
  logic [5:0]        stack_q [StackDepth];
  logic [5:0]        stack_d [StackDepth];
  logic [PtrW-1:0]   sp_q, sp_d;
  logic [31:0]       rem_q, rem_d;
  logic [6:0]        lol_q, lol_d;
  logic [31:0]       acc_q, acc_d;

  logic [5:0]        top;
  logic              sp_full;
  logic [IdxW-1:0]   sp_idx, spm1_idx;
  logic              ev;
  out_item_t         item;
  logic              is_int;
  logic [31:0]       rem_new;
  logic              len_fin;
  logic [5:0]        child;
  logic              id_sel;
  logic [5:0]        code_save;
  node_kind_e        tk;
  logic [31:0]       rem_dec;

  assign sp_full  = (sp_q >= PtrW'(StackDepth));
  assign sp_idx   = sp_q[IdxW-1:0];
  assign spm1_idx = IdxW'(sp_q - PtrW'(1));
  assign top      = (sp_q == '0 || sp_q > PtrW'(StackDepth)) ? 6'd0 : stack_q[spm1_idx];
  assign tk       = kind_of(top);
  assign rem_dec  = rem_q - 32'd1;

  always_comb begin
    phase_d = phase_q;
    stack_d = stack_q;
    sp_d    = sp_q;
    rem_d   = rem_q;
    lol_d   = lol_q;
    acc_d   = acc_q;
    ev      = 1'b0;
    item    = '0;
    is_int  = 1'b0;
    rem_new = rem_q;
    len_fin = 1'b0;
    child   = 6'd0;
    id_sel  = 1'b0;
    code_save = top;

    // Tag handling, shared by the plain tag phase and the one after a string.
    if (phase_q == PTag || phase_q == PTagSe) begin
      if (top == 6'd0) begin
        ev = 1'b1;
      end else if (byte_i == TagEoc) begin
        phase_d = PEoc2;
      end else if (byte_i == TagStr && tk == KStr) begin
        phase_d = PSlen;
      end else if (byte_i == TagInt && (tk == KInt || tk == KWlist)) begin
        phase_d = PIlen;
      end else begin
        if (top == NIdseq && byte_i >= TagIdLo && byte_i <= TagIdHi) begin
          id_sel = 1'b1;
          child  = id_choice(5'(byte_i - TagIdLo));
        end else begin
          child = child_of(top, byte_i);
        end
        if (child == 6'd0 || sp_full) begin
          ev = 1'b1;
        end else begin
          stack_d[sp_idx] = child;
          phase_d = PClen;
          if (id_sel) begin
            ev = 1'b1;
            item.event_kind = EvId;
            item.field_code = 6'(byte_i - TagIdLo);
          end
        end
      end
      if (ev && item.event_kind != EvId) begin
        item.event_kind = EvErr;
        item.field_code = top;
        item.event_value = {24'd0, byte_i};
      end else if (!ev && phase_q == PTagSe) begin
        ev = 1'b1;
        item.event_kind = EvSend;
        item.field_code = code_save;
      end
    end else begin
      unique case (phase_q)
        PIdle: begin
          if (byte_i != TagSeq) ev = 1'b1;
          else phase_d = PIdleLen;
        end
        PIdleLen: begin
          if (byte_i != TagIndef) ev = 1'b1;
          else begin
            stack_d[0] = NList;
            sp_d = PtrW'(1);
            phase_d = PTag;
          end
        end
        PClen: begin
          if (byte_i != TagIndef || sp_full) ev = 1'b1;
          else if (kind_of(stack_q[sp_idx]) == KWrap ||
                   kind_of(stack_q[sp_idx]) == KWlist) phase_d = PW30;
          else begin
            sp_d = sp_q + PtrW'(1);
            phase_d = PTag;
          end
        end
        PW30: begin
          if (byte_i != TagSeq) ev = 1'b1;
          else phase_d = PW80;
        end
        PW80: begin
          if (byte_i != TagIndef || sp_full) ev = 1'b1;
          else begin
            sp_d = sp_q + PtrW'(1);
            phase_d = PTag;
          end
        end
        PEoc2: begin
          if (byte_i != TagEoc || top == 6'd0) ev = 1'b1;
          else begin
            sp_d = sp_q - PtrW'(1);
            stack_d[spm1_idx] = 6'd0;
            if (top == NList) begin
              ev = 1'b1;
              item.event_kind = EvList;
              item.field_code = NList;
            end else if (tk == KWrap || tk == KWlist) begin
              phase_d = PEoc3;
            end else begin
              phase_d = PTag;
              if (top == NDef) begin
                ev = 1'b1;
                item.event_kind = EvRec;
                item.field_code = NDef;
              end
            end
          end
        end
        PEoc3: begin
          if (byte_i != TagEoc) ev = 1'b1;
          else phase_d = PEoc4;
        end
        PEoc4: begin
          if (byte_i != TagEoc) ev = 1'b1;
          else phase_d = PTag;
        end
        PSlen, PIlen: begin
          is_int = (phase_q == PIlen);
          if (byte_i < TagIndef) begin
            rem_new = {24'd0, byte_i};
            len_fin = 1'b1;
          end else if (byte_i == TagIndef) begin
            ev = 1'b1;
          end else begin
            lol_d = byte_i[6:0];
            rem_d = 32'd0;
            phase_d = is_int ? PIlenx : PSlenx;
          end
        end
        PSlenx, PIlenx: begin
          is_int  = (phase_q == PIlenx);
          rem_new = {rem_q[23:0], byte_i};
          rem_d   = rem_new;
          lol_d   = (lol_q != 7'd0) ? lol_q - 7'd1 : lol_q;
          len_fin = (lol_q <= 7'd1);
        end
        PSdata: begin
          rem_d = rem_dec;
          if (rem_dec == 32'd0) phase_d = PTagSe;
          ev = 1'b1;
          item.event_kind  = EvSbyte;
          item.field_code  = top;
          item.event_value = {24'd0, byte_i};
        end
        PIfirst, PIdata: begin
          if (phase_q == PIfirst) acc_d = byte_i[7] ? {24'hFFFFFF, byte_i} : {24'd0, byte_i};
          else acc_d = {acc_q[23:0], byte_i};
          rem_d = rem_dec;
          if (rem_dec == 32'd0) begin
            phase_d = PTag;
            ev = 1'b1;
            item.event_kind  = EvInt;
            item.field_code  = top;
            item.event_value = acc_d;
          end else begin
            phase_d = PIdata;
          end
        end
        default: ev = 1'b1;
      endcase

      if (len_fin) begin
        rem_d = rem_new;
        if (rem_new == 32'd0) begin
          phase_d = PTag;
          ev = 1'b1;
          item.event_kind = is_int ? EvInt : EvSend;
          item.field_code = top;
        end else if (!is_int) begin
          phase_d = PSdata;
        end else if (rem_new > 32'(IntBytes)) begin
          ev = 1'b1;
        end else begin
          phase_d = PIfirst;
        end
      end

      // Any event not set to another kind here is an error.
      if (ev && item.event_kind == EvSbyte && phase_q != PSdata) begin
        item.event_kind  = EvErr;
        item.field_code  = top;
        item.event_value = {24'd0, byte_i};
      end
    end

    if (ev && (item.event_kind == EvErr || item.event_kind == EvList)) begin
      phase_d = PIdle;
      for (int i = 0; i < StackDepth; i++) stack_d[i] = 6'd0;
      sp_d  = '0;
      rem_d = 32'd0;
      lol_d = 7'd0;
      acc_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PIdle;
      for (int i = 0; i < StackDepth; i++) stack_q[i] <= 6'd0;
      sp_q  <= '0;
      rem_q <= 32'd0;
      lol_q <= 7'd0;
      acc_q <= 32'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      stack_q <= stack_d;
      sp_q    <= sp_d;
      rem_q   <= rem_d;
      lol_q   <= lol_d;
      acc_q   <= acc_d;
    end
  end

  assign ev_valid_o = step_i && ev;
  assign ev_o       = item;
endmodule

// ----- hw/rtl/bshp_out_reg.sv -----
// -----------------------------------------------------------------------------
// bshp_out_reg
// Two-entry skid buffer for result requests.
// -----------------------------------------------------------------------------
module bshp_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  bshp_pkg::out_item_t in_item_i,
  output logic                space_o,
  bshp_stream_if.source       out_o
);
  import bshp_pkg::*;

  out_item_t main_q, skid_q;
  logic      main_vld_q, skid_vld_q;
  logic      pop;

  assign pop           = out_o.valid && out_o.ready;
  assign space_o       = !skid_vld_q;
  assign out_o.valid   = main_vld_q;
  assign out_o.payload = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!main_vld_q || pop) begin
        main_vld_q <= skid_vld_q || in_valid_i;
        skid_vld_q <= 1'b0;
      end else if (in_valid_i) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      main_q <= skid_vld_q ? skid_q : in_item_i;
    end
    if (in_valid_i && !(!main_vld_q || pop) || (in_valid_i && skid_vld_q)) begin
      skid_q <= in_item_i;
    end
  end
endmodule

// ----- hw/rtl/bshp_checker.sv -----
// -----------------------------------------------------------------------------
// bshp_checker
// Port-level checks of the sequence-header parser.
// -----------------------------------------------------------------------------
`include "ber_sequence_header_parser_macros.svh"
module bshp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [40:0] out_payload
);
  import bshp_pkg::*;

  `BSHP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_payload), "result dropped while stalled")
  `BSHP_ASSERT_IMP(a_kind_range, clk_i, rst_ni, out_valid, out_payload[40:38] <= EvErr, "bad event kind")
  `BSHP_ASSERT_NXT(a_ready_back, clk_i, rst_ni, !in_ready && out_ready, in_ready, "input stalled after drain")
  `BSHP_ASSERT_IMP(a_end_zero, clk_i, rst_ni, out_valid && (out_payload[40:38] == EvRec || out_payload[40:38] == EvList), out_payload[31:0] == 32'd0, "end event carries value")
endmodule

bind ber_sequence_header_parser bshp_checker u_bshp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_payload(out_o.payload)
);

// ----- sim/ber_sequence_header_parser_test.sv -----
// -----------------------------------------------------------------------------
// ber_sequence_header_parser_test
// Drives BER byte streams of sequence-header records, well-formed and broken,
// into the parser and compares every emitted event with a behavioral
// predictor of the decoder.
// -----------------------------------------------------------------------------
class bshp_event_scoreboard;
  localparam int Depth = bshp_pkg::StackDepthDef;
  localparam int MaxIntOctets = bshp_pkg::IntBytesDef;

  typedef enum int {
    SIdle, SIdleLen, STag, STagSe, SClen, SW30, SW80, SEoc2, SEoc3, SEoc4,
    SSlen, SSlenx, SSdata, SIlen, SIlenx, SIfirst, SIdata
  } phase_e;

  phase_e phase;
  logic [5:0] ctx [Depth];
  int unsigned depth_used;
  logic [31:0] remaining;
  int unsigned octets_left;
  logic [31:0] accum;
  bshp_pkg::out_item_t expected_events[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
    clear();
  endfunction

  function void clear();
    phase = SIdle;
    foreach (ctx[i]) ctx[i] = 6'd0;
    depth_used = 0;
    remaining = 0;
    octets_left = 0;
    accum = 0;
  endfunction

  function void push_event(bshp_pkg::event_kind_e k, logic [5:0] code, logic [31:0] v);
    bshp_pkg::out_item_t e;
    e.event_kind = k;
    e.field_code = code;
    e.event_value = v;
    expected_events.push_back(e);
  endfunction

  function logic [5:0] top();
    if (depth_used == 0 || depth_used > Depth) return 6'd0;
    return ctx[depth_used - 1];
  endfunction

  function void raise_error(logic [7:0] b);
    logic [5:0] code;
    code = top();
    clear();
    push_event(bshp_pkg::EvErr, code, {24'd0, b});
  endfunction

  function logic [5:0] schema_child(logic [5:0] t, logic [7:0] b);
    int i;
    i = b - 8'hA0;
    if (t == 6'd1) return (b == 8'h30) ? 6'd2 : 6'd0;
    if (b < 8'hA0 || b > 8'hAF) return 6'd0;
    case (t)
      6'd2:  if (i <= 5) return 6'(3 + i);
      6'd10: if (i <= 1) return 6'(11 + i);
      6'd13: if (i <= 2) return 6'(14 + i);
      6'd17: if (i <= 3) return 6'(18 + i);
      6'd22: if (i <= 1) return 6'(23 + i);
      6'd24: if (i <= 1) return 6'(25 + i); else if (i == 2) return 6'd29;
      6'd26: if (i <= 1) return 6'(27 + i);
      6'd30: if (i <= 1) return 6'(31 + i);
      6'd32: if (i <= 1) return 6'(33 + i);
      6'd35: if (i <= 3) return 6'(36 + i);
      6'd38: if (i <= 1) return 6'(40 + i);
      6'd41: if (i <= 6) return 6'(42 + i);
      default: ;
    endcase
    return 6'd0;
  endfunction

  function logic [5:0] choice_node(int c);
    case (c)
      0: return 6'd10;
      1, 2, 11: return 6'd9;
      3: return 6'd13;
      8: return 6'd22;
      10: return 6'd30;
      14: return 6'd35;
      default: return 6'd17;
    endcase
  endfunction

  // Returns 1 when an event was queued.
  function bit tag_byte(logic [7:0] b);
    logic [5:0] t, child;
    bshp_pkg::node_kind_e k;
    bit id_start;
    t = top();
    k = bshp_pkg::node_kind_e'(kind_code(t));
    id_start = 0;
    child = 0;
    if (t == 0) begin raise_error(b); return 1; end
    if (b == bshp_pkg::TagEoc) begin phase = SEoc2; return 0; end
    if (b == bshp_pkg::TagStr && k == bshp_pkg::KStr) begin phase = SSlen; return 0; end
    if (b == bshp_pkg::TagInt && (k == bshp_pkg::KInt || k == bshp_pkg::KWlist)) begin
      phase = SIlen;
      return 0;
    end
    if (t == bshp_pkg::NIdseq && b >= bshp_pkg::TagIdLo && b <= bshp_pkg::TagIdHi) begin
      child = choice_node(b - 8'hA0);
      id_start = 1;
    end else begin
      child = schema_child(t, b);
    end
    if (child == 0 || depth_used >= Depth) begin raise_error(b); return 1; end
    ctx[depth_used] = child;
    phase = SClen;
    if (id_start) begin
      push_event(bshp_pkg::EvId, 6'(b - 8'hA0), 0);
      return 1;
    end
    return 0;
  endfunction

  function int kind_code(logic [5:0] n);
    case (n)
      3, 12, 15, 16, 18, 19, 20, 25, 27, 28, 29, 31, 34, 36, 39, 40, 45:
        return bshp_pkg::KStr;
      5, 9, 11, 14, 21, 23, 33, 37, 42, 43, 44, 46, 47, 48: return bshp_pkg::KInt;
      4, 13, 17, 22, 24, 30, 35, 41: return bshp_pkg::KWrap;
      6, 7, 8: return bshp_pkg::KWlist;
      default: return bshp_pkg::KSeq;
    endcase
  endfunction

  function void length_complete(bit is_int, logic [7:0] b);
    if (remaining == 0) begin
      phase = STag;
      push_event(is_int ? bshp_pkg::EvInt : bshp_pkg::EvSend, top(), 0);
    end else if (!is_int) begin
      phase = SSdata;
    end else if (remaining > MaxIntOctets) begin
      raise_error(b);
    end else begin
      phase = SIfirst;
    end
  endfunction

  function void length_start(bit is_int, logic [7:0] b);
    if (b < 8'h80) begin
      remaining = {24'd0, b};
      length_complete(is_int, b);
    end else if (b == 8'h80) begin
      raise_error(b);
    end else begin
      octets_left = 32'(b[6:0]);
      remaining = 0;
      phase = is_int ? SIlenx : SSlenx;
    end
  endfunction

  function void length_more(bit is_int, logic [7:0] b);
    remaining = {remaining[23:0], b};
    if (octets_left > 0) octets_left--;
    if (octets_left == 0) length_complete(is_int, b);
  endfunction

  function void int_octet_done();
    remaining--;
    if (remaining == 0) begin
      phase = STag;
      push_event(bshp_pkg::EvInt, top(), accum);
    end else begin
      phase = SIdata;
    end
  endfunction

  function void note_byte(logic [7:0] b);
    logic [5:0] code, n;
    int k;
    case (phase)
      SIdle: if (b != bshp_pkg::TagSeq) raise_error(b); else phase = SIdleLen;
      SIdleLen:
        if (b != bshp_pkg::TagIndef) raise_error(b);
        else begin
          ctx[0] = bshp_pkg::NList;
          depth_used = 1;
          phase = STag;
        end
      STag: void'(tag_byte(b));
      STagSe: begin
        code = top();
        if (!tag_byte(b)) push_event(bshp_pkg::EvSend, code, 0);
      end
      SClen:
        if (b != bshp_pkg::TagIndef || depth_used >= Depth) raise_error(b);
        else begin
          k = kind_code(ctx[depth_used]);
          if (k == bshp_pkg::KWrap || k == bshp_pkg::KWlist) phase = SW30;
          else begin depth_used++; phase = STag; end
        end
      SW30: if (b != bshp_pkg::TagSeq) raise_error(b); else phase = SW80;
      SW80:
        if (b != bshp_pkg::TagIndef || depth_used >= Depth) raise_error(b);
        else begin depth_used++; phase = STag; end
      SEoc2:
        if (b != 8'h00 || depth_used == 0 || depth_used > Depth) raise_error(b);
        else begin
          depth_used--;
          n = ctx[depth_used];
          ctx[depth_used] = 0;
          k = kind_code(n);
          if (n == bshp_pkg::NList) begin
            clear();
            push_event(bshp_pkg::EvList, bshp_pkg::NList, 0);
          end else if (k == bshp_pkg::KWrap || k == bshp_pkg::KWlist) begin
            phase = SEoc3;
          end else begin
            phase = STag;
            if (n == bshp_pkg::NDef) push_event(bshp_pkg::EvRec, bshp_pkg::NDef, 0);
          end
        end
      SEoc3: if (b != 8'h00) raise_error(b); else phase = SEoc4;
      SEoc4: if (b != 8'h00) raise_error(b); else phase = STag;
      SSlen: length_start(0, b);
      SSlenx: length_more(0, b);
      SSdata: begin
        remaining--;
        if (remaining == 0) phase = STagSe;
        push_event(bshp_pkg::EvSbyte, top(), {24'd0, b});
      end
      SIlen: length_start(1, b);
      SIlenx: length_more(1, b);
      SIfirst: begin
        accum = b[7] ? {24'hFFFFFF, b} : {24'd0, b};
        int_octet_done();
      end
      SIdata: begin
        accum = {accum[23:0], b};
        int_octet_done();
      end
      default: raise_error(b);
    endcase
  endfunction

  function void check_event(bshp_pkg::out_item_t got);
    bshp_pkg::out_item_t want;
    if (expected_events.size() == 0) begin
      $error("unexpected event kind %0d code %0d value %h",
             got.event_kind, got.field_code, got.event_value);
      mismatches++;
      return;
    end
    want = expected_events.pop_front();
    if (got.event_kind !== want.event_kind) begin
      $error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
      mismatches++;
    end
    if (got.field_code !== want.field_code) begin
      $error("field_code: expected %0d, actual %0d", want.field_code, got.field_code);
      mismatches++;
    end
    if (got.event_value !== want.event_value) begin
      $error("event_value: expected %h, actual %h", want.event_value, got.event_value);
      mismatches++;
    end
  endfunction
endclass

module ber_sequence_header_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bshp_stream_if #(.payload_t(bshp_pkg::in_item_t)) in_ch();
  bshp_stream_if #(.payload_t(bshp_pkg::out_item_t)) out_ch();

  ber_sequence_header_parser dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_ch.sink),
    .out_o(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  bshp_event_scoreboard events = new();
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_off_cycles;
  logic [7:0] byte_stream[$];

  // Sender: offers queued bytes, notes each accepted request.
  task automatic send_stream();
    logic [7:0] b;
    while (byte_stream.size() > 0) begin
      b = byte_stream.pop_front();
      if ($urandom_range(99) < send_idle_pct) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
      end
      in_ch.valid <= 1'b1;
      in_ch.payload <= b;
      do @(posedge clk_i); while (!in_ch.ready);
      events.note_byte(b);
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i)
    if (rst_ni && out_ch.valid && out_ch.ready) events.check_event(out_ch.payload);

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Byte builders for well-formed records.
  task automatic put(input logic [7:0] b);
    byte_stream.push_back(b);
  endtask

  task automatic put_len(input int n);
    if (n < 128 && $urandom_range(3) != 0) put(8'(n));
    else begin
      put(8'h82);
      put(8'(n >> 8));
      put(8'(n));
    end
  endtask

  task automatic put_str(input int n);
    put(8'h1A);
    put_len(n);
    repeat (n) put(8'($urandom));
  endtask

  task automatic put_int(input int n);
    put(8'h02);
    put_len(n);
    repeat (n) put(8'($urandom));
  endtask

  task automatic put_eoc();
    put(8'h00);
    put(8'h00);
  endtask

  task automatic put_date();
    int f;
    put(8'hA1); put(8'h80); put(8'h30); put(8'h80);
    repeat ($urandom_range(1, 3)) begin
      f = $urandom_range(0, 6);
      put(8'(8'hA0 + f)); put(8'h80);
      if (f == 3) put_str($urandom_range(0, 3)); else put_int($urandom_range(0, 4));
      put_eoc();
    end
    put_eoc(); put_eoc();
  endtask

  task automatic put_seq_id();
    int c;
    c = $urandom_range(0, 19);
    put(8'(8'hA0 + c)); put(8'h80);
    case (c)
      0: begin
        put(8'(8'hA0 + $urandom_range(1))); put(8'h80);
        if (byte_stream[$ - 1] == 8'hA0) put_int($urandom_range(0, 4));
        else put_str($urandom_range(0, 4));
        put_eoc();
      end
      1, 2, 11: put_int($urandom_range(1, 4));
      3: begin
        put(8'h30); put(8'h80);
        put(8'hA0); put(8'h80); put_int($urandom_range(1, 4)); put_eoc();
        put(8'hA1); put(8'h80); put_str($urandom_range(1, 4)); put_eoc();
        put_eoc();
      end
      8: begin
        put(8'h30); put(8'h80);
        put(8'hA1); put(8'h80); put(8'h30); put(8'h80);
        put(8'hA0); put(8'h80); put_str($urandom_range(1, 3)); put_eoc();
        put(8'hA1); put(8'h80);
        put(8'(8'hA0 + $urandom_range(1))); put(8'h80); put_str(2); put_eoc();
        put_eoc();
        put(8'hA2); put(8'h80); put_str(1); put_eoc();
        put_eoc(); put_eoc();
        put_eoc();
      end
      10: begin
        put(8'h30); put(8'h80);
        put(8'hA0); put(8'h80); put_str($urandom_range(1, 3)); put_eoc();
        put(8'hA1); put(8'h80);
        put(8'hA0); put(8'h80); put_int($urandom_range(0, 4)); put_eoc();
        put_eoc();
        put_eoc();
      end
      14: begin
        put(8'h30); put(8'h80);
        put(8'hA0); put(8'h80); put_str($urandom_range(1, 3)); put_eoc();
        put(8'hA1); put(8'h80); put_int($urandom_range(1, 4)); put_eoc();
        put(8'hA2); put(8'h80); put_date(); put_eoc();
        put(8'hA3); put(8'h80); put_str(2); put_eoc();
        put_eoc();
      end
      default: begin
        put(8'h30); put(8'h80);
        repeat ($urandom_range(1, 2)) begin
          put(8'(8'hA0 + $urandom_range(3))); put(8'h80);
          if (byte_stream[$] == 8'h80 && byte_stream[$ - 1] == 8'hA3)
            put_int($urandom_range(1, 4));
          else put_str($urandom_range(0, 5));
          put_eoc();
        end
        put_eoc();
      end
    endcase
    put_eoc();
  endtask

  task automatic put_record();
    int f;
    put(8'h30); put(8'h80);
    repeat ($urandom_range(1, 4)) begin
      f = $urandom_range(0, 5);
      put(8'(8'hA0 + f)); put(8'h80);
      case (f)
        0: put_str($urandom_range(0, 8));
        1: begin
          put(8'h30); put(8'h80);
          repeat ($urandom_range(1, 2)) put_seq_id();
          put_eoc();
        end
        2: put_int($urandom_range(0, 4));
        default: begin
          put(8'h30); put(8'h80);
          repeat ($urandom_range(0, 3)) put_int($urandom_range(0, 4));
          put_eoc();
        end
      endcase
      put_eoc();
    end
    put_eoc();
  endtask

  task automatic put_list();
    put(8'h30); put(8'h80);
    repeat ($urandom_range(1, 2)) put_record();
    put_eoc();
  endtask

  // Random corruption: drop, replace or insert one byte in a good list.
  task automatic put_broken_list();
    int start, pos;
    start = byte_stream.size();
    put_list();
    pos = start + $urandom_range(byte_stream.size() - start - 1);
    case ($urandom_range(2))
      0: byte_stream[pos] = 8'($urandom);
      1: byte_stream.delete(pos);
      default: byte_stream.insert(pos, 8'($urandom));
    endcase
  endtask

  task automatic directed_bytes();
    put(8'hFF);                                  // error before a list
    put(8'h30); put(8'h80);                      // list
    put(8'h30); put(8'h80);                      // record
    put(8'hA0); put(8'h80); put(8'h1A); put(8'h00); put_eoc();   // empty title
    put(8'hA2); put(8'h80); put(8'h02); put(8'h00);               // zero-length int
    put(8'h02); put(8'h04); put(8'h80); put(8'h00); put(8'h00); put(8'h01);
    put(8'h02); put(8'h01); put(8'h7F);
    put_eoc();
    put_eoc(); put_eoc();
    put(8'h30); put(8'h80); put(8'hA2); put(8'h80);
    put(8'h02); put(8'h05);                      // errors: A2 outside a record, then 02 05 in idle
    put(8'h30); put(8'h80); put(8'h30); put(8'h80);
    put(8'hA0); put(8'h80); put(8'h1A); put(8'h80); // primitive indefinite
  endtask

  task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
                           input int unsigned n_bytes);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (byte_stream.size() < n_bytes) begin
      if ($urandom_range(9) < 8) put_list();
      else if ($urandom_range(1)) put_broken_list();
      else repeat ($urandom_range(1, 4)) put(8'($urandom));
    end
    send_stream();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    hold_off_cycles = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_bytes();
    run_phase(8, 58, 480);
    run_phase(58, 8, 480);
    hold_off_cycles = 60;
    run_phase(0, 0, 480);
    in_ch.valid <= 1'b0;

    wait (events.expected_events.size() == 0 && hold_off_cycles == 0);
    repeat (20) @(posedge clk_i);
    if (events.mismatches == 0 && events.expected_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/bshp_pkg.sv
hw/rtl/bshp_stream_if.sv
hw/rtl/bshp_core.sv
hw/rtl/bshp_out_reg.sv
hw/rtl/ber_sequence_header_parser.sv
hw/rtl/bshp_checker.sv
sim/ber_sequence_header_parser_test.sv
